FILE: rtl/bfp_pkg.sv
// Shared types and constants of the bit field packer.
`timescale 1ns / 1ps

package bfp_pkg;

	// Widest field that the block accepts; counts above it saturate.
	localparam int MAX_FIELD_BITS = 32;

	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = 6;
	localparam int BYTE_BITS  = 8;
	localparam int PEND_BITS  = BYTE_BITS - 1;
	localparam int PCNT_BITS  = 3;
	localparam int ACC_BITS   = PEND_BITS + VALUE_BITS;
	localparam int MAX_BYTES  = ACC_BITS / BYTE_BITS;
	localparam int NB_BITS    = $clog2(MAX_BYTES + 1);
	localparam int BIDX_BITS  = $clog2(MAX_BYTES);
	localparam int FIELD_CAP  = (MAX_FIELD_BITS < VALUE_BITS) ? MAX_FIELD_BITS : VALUE_BITS;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	// One group of completed bytes, sent out byte 0 first.
	typedef struct packed {
		logic [MAX_BYTES*BYTE_BITS-1:0] data;
		logic [BIDX_BITS-1:0]           last_idx;
	} entry_t;

endpackage

FILE: rtl/bfp_if.sv
// Valid/ready channel interfaces for the input items and the output bytes.
`timescale 1ns / 1ps

interface bfp_in_if;
	logic                              valid;
	logic                              ready;
	logic                              op;
	logic [bfp_pkg::VALUE_BITS-1:0]    field_value;
	logic [bfp_pkg::COUNT_BITS-1:0]    bit_count;

	modport source (output valid, output op, output field_value, output bit_count, input ready);
	modport sink (input valid, input op, input field_value, input bit_count, output ready);
endinterface

interface bfp_out_if;
	logic                             valid;
	logic                             ready;
	logic [bfp_pkg::BYTE_BITS-1:0]    out_byte;
	logic                             is_last;

	modport source (output valid, output out_byte, output is_last, input ready);
	modport sink (input valid, input out_byte, input is_last, output ready);
endinterface

FILE: rtl/bfp_front.sv
// Front end: accepts items, merges field bits with the pending bits, queues full bytes and flushed partial bytes.
`timescale 1ns / 1ps

module bfp_front (
	input  logic              clk,
	input  logic              arst_n,
	bfp_in_if.sink            item,
	output logic              push,
	output bfp_pkg::entry_t   push_entry,
	input  logic              full
);

	logic [bfp_pkg::PEND_BITS-1:0]  pend_bits_q;
	logic [bfp_pkg::PCNT_BITS-1:0]  pend_cnt_q;

	logic                            accept;
	logic                            is_flush;
	logic [bfp_pkg::COUNT_BITS-1:0]  n_sat;
	logic [bfp_pkg::VALUE_BITS:0]    one_sh;
	logic [bfp_pkg::VALUE_BITS-1:0]  mask;
	logic [bfp_pkg::ACC_BITS-1:0]    acc;
	logic [bfp_pkg::ACC_BITS-1:0]    acc_rest;
	logic [bfp_pkg::COUNT_BITS-1:0]  total;
	logic [bfp_pkg::NB_BITS-1:0]     nbytes;

	assign item.ready = !full;
	assign accept     = item.valid && item.ready;
	assign is_flush   = (item.op == bfp_pkg::OP_FLUSH);

	always_comb begin
		if (item.bit_count > bfp_pkg::COUNT_BITS'(bfp_pkg::FIELD_CAP)) begin
			n_sat = bfp_pkg::COUNT_BITS'(bfp_pkg::FIELD_CAP);
		end else begin
			n_sat = item.bit_count;
		end
		one_sh = (bfp_pkg::VALUE_BITS+1)'(1) << n_sat;
		if (n_sat >= bfp_pkg::COUNT_BITS'(bfp_pkg::VALUE_BITS)) begin
			mask = '1;
		end else begin
			mask = bfp_pkg::VALUE_BITS'(one_sh - (bfp_pkg::VALUE_BITS+1)'(1));
		end
		// New bits land just above the pending ones.
		acc = bfp_pkg::ACC_BITS'(pend_bits_q)
			| (bfp_pkg::ACC_BITS'(item.field_value & mask) << pend_cnt_q);
		total    = bfp_pkg::COUNT_BITS'(pend_cnt_q) + n_sat;
		nbytes   = bfp_pkg::NB_BITS'(total >> 3);
		acc_rest = acc >> {nbytes, 3'b000};
	end

	always_comb begin
		push_entry = '0;
		if (is_flush) begin
			push               = accept && (pend_cnt_q != '0);
			push_entry.data    = (bfp_pkg::MAX_BYTES*bfp_pkg::BYTE_BITS)'(pend_bits_q);
			push_entry.last_idx = '0;
		end else begin
			push                = accept && (nbytes != '0);
			push_entry.data     = acc[bfp_pkg::MAX_BYTES*bfp_pkg::BYTE_BITS-1:0];
			push_entry.last_idx = bfp_pkg::BIDX_BITS'(nbytes - bfp_pkg::NB_BITS'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (accept) begin
			if (is_flush) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end else begin
				pend_bits_q <= acc_rest[bfp_pkg::PEND_BITS-1:0];
				pend_cnt_q  <= total[bfp_pkg::PCNT_BITS-1:0];
			end
		end
	end

	a_write_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept && !is_flush) |-> pend_cnt_q == $past(total[bfp_pkg::PCNT_BITS-1:0]))
		else $error("pending count does not follow the accepted write");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept && is_flush) |-> (pend_cnt_q == '0 && pend_bits_q == '0))
		else $error("flush did not clear the pending bits");

endmodule

FILE: rtl/bfp_queue.sv
// Two-entry queue of byte groups between the front and back ends.
`timescale 1ns / 1ps

module bfp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bfp_pkg::entry_t   push_entry,
	output logic              full,
	input  logic              pop,
	output bfp_pkg::entry_t   head,
	output logic              empty
);

	bfp_pkg::entry_t                 mem_q [bfp_pkg::QUEUE_DEPTH];
	logic [bfp_pkg::QPTR_BITS-1:0]   wr_ptr_q;
	logic [bfp_pkg::QPTR_BITS-1:0]   rd_ptr_q;
	logic [bfp_pkg::QCNT_BITS-1:0]   cnt_q;

	assign full  = (cnt_q == bfp_pkg::QCNT_BITS'(bfp_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty queue");

endmodule

FILE: rtl/bfp_back.sv
// Back end: sends the bytes of the head queue entry one per transfer.
`timescale 1ns / 1ps

module bfp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bfp_pkg::entry_t   head,
	input  logic              empty,
	output logic              pop,
	bfp_out_if.source         stream
);

	logic [bfp_pkg::BIDX_BITS-1:0]  byte_idx_q;
	logic                            xfer;

	assign stream.valid    = !empty;
	assign stream.out_byte = head.data[{byte_idx_q, 3'b000} +: bfp_pkg::BYTE_BITS];
	assign stream.is_last  = (byte_idx_q == head.last_idx);
	assign xfer            = stream.valid && stream.ready;
	assign pop             = xfer && stream.is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
		end else if (xfer) begin
			if (stream.is_last) begin
				byte_idx_q <= '0;
			end else begin
				byte_idx_q <= byte_idx_q + 1'b1;
			end
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> byte_idx_q <= head.last_idx)
		else $error("byte index ran past the last byte of the entry");

endmodule

FILE: rtl/bit_field_packer.sv
// Top level of the LSB-first bit field packer.
`timescale 1ns / 1ps

// The packer appends fields of 1 to 32 bits to a byte stream, least
// significant bit first, and sends each byte as soon as it is full, so a
// multi-byte field leaves in little-endian order. A write item (op 0) uses
// the low bit_count bits of field_value; higher bits are ignored, a count
// above 32 counts as 32, and a count of zero appends nothing. A flush item
// (op 1) sends the waiting partial byte, zero filled above its used bits,
// and clears the state; with nothing waiting it sends nothing. The byte that
// ends the output of an item carries is_last. The front end takes one item
// per clock whenever its two-entry queue has room, so writes may come back
// to back; the output side sends one byte per transfer, so a write holds
// the output for as many transfers as the bytes it completes (up to four for
// a 32-bit field), and items that complete no byte send nothing. The bytes
// of an accepted item are registered in the queue before they leave.

module bit_field_packer (
	input  logic   clk,
	input  logic   arst_n,
	bfp_in_if.sink     item,
	bfp_out_if.source  stream
);

	// Interface between front end, queue and back end.
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;
	bfp_pkg::entry_t  push_entry;
	bfp_pkg::entry_t  head;

	// Front end: keeps the pending bits and turns every item that completes
	// a byte, and every flush with bits waiting, into a group of bytes.
	bfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	// The queue lets the front end keep accepting while bytes wait for
	// transfer on the output side.
	bfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	// Back end: one byte per output transfer.
	bfp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.stream (stream)
	);

endmodule
